// ===== design/rfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpf_pkg
// shared constants, types and index helpers of the five-byte packet framer
// ----------------------------------------------------------------------------
`default_nettype none

package rfpf_pkg;

  // ring size, 8 to 1024 bytes
  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned PKT_LEN      = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   idx_ext_t;

  localparam idx_ext_t DEPTH_EXT   = idx_ext_t'(BUFFER_DEPTH);
  localparam idx_ext_t PKT_LEN_EXT = idx_ext_t'(PKT_LEN);
  localparam idx_t     IDX_LAST    = idx_t'(BUFFER_DEPTH - 1);

  // item actions
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_ERR  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd50;

  typedef struct packed {
    logic       packet_ready;
    logic       read_ok;
    logic [7:0] pkt_byte0;
    logic [7:0] pkt_byte1;
    logic [7:0] pkt_byte2;
    logic [7:0] pkt_byte3;
    logic [7:0] pkt_byte4;
    logic       timeout_flag;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic idx_t idx_next(idx_t i);
    return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // move back by n entries, n below the depth
  function automatic idx_t idx_back(idx_t i, logic [2:0] n);
    idx_ext_t wi;
    idx_ext_t wn;
    wi = {1'b0, i};
    wn = idx_ext_t'(n);
    if (wi >= wn) begin
      return idx_t'(wi - wn);
    end
    return idx_t'(wi + DEPTH_EXT - wn);
  endfunction

  // bytes between read and write index
  function automatic idx_ext_t idx_avail(idx_t w, idx_t r);
    if (w >= r) begin
      return idx_ext_t'(w - r);
    end
    return idx_ext_t'({1'b0, w} + DEPTH_EXT - {1'b0, r});
  endfunction

  function automatic idx_t idx_add_pkt(idx_t r);
    idx_ext_t s;
    s = {1'b0, r} + PKT_LEN_EXT;
    if (s >= DEPTH_EXT) begin
      return idx_t'(s - DEPTH_EXT);
    end
    return idx_t'(s);
  endfunction

  // scan codes in order, a zero code ends the list
  function automatic logic code_match(logic [3:0][7:0] codes, logic [7:0] b);
    logic hit;
    logic stop;
    hit  = 1'b0;
    stop = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!stop) begin
        if (codes[k] == 8'd0) begin
          stop = 1'b1;
        end else if (codes[k] == b) begin
          hit  = 1'b1;
          stop = 1'b1;
        end
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== design/rfpf_if.sv =====
// ----------------------------------------------------------------------------
// rfpf_if
// valid/ready channels of the packet framer: input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface rfpf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface rfpf_out_if;
  logic       valid;
  logic       ready;
  logic       packet_ready;
  logic       read_ok;
  logic [7:0] pkt_byte0;
  logic [7:0] pkt_byte1;
  logic [7:0] pkt_byte2;
  logic [7:0] pkt_byte3;
  logic [7:0] pkt_byte4;
  logic       timeout_flag;

  modport source (output valid, output packet_ready, output read_ok,
                  output pkt_byte0, output pkt_byte1, output pkt_byte2,
                  output pkt_byte3, output pkt_byte4, output timeout_flag,
                  input ready);
  modport sink   (input valid, input packet_ready, input read_ok,
                  input pkt_byte0, input pkt_byte1, input pkt_byte2,
                  input pkt_byte3, input pkt_byte4, input timeout_flag,
                  output ready);
endinterface

`default_nettype wire

// ===== design/rx_five_byte_packet_framer.sv =====
// ----------------------------------------------------------------------------
// rx_five_byte_packet_framer
// frames received bytes into five-byte command packets in a byte ring
// ----------------------------------------------------------------------------
// usage
//   in_i carries one item per handshake: a received byte, a line error, a
//   timer tick or a packet read request. every item gives exactly one result
//   item on out_o, in order.
//   byte, error and tick items: the result is queued at the accepting edge
//   and shows on out_o the next cycle. a new item can be taken every cycle
//   while no fetch runs and the two-entry result queue has room.
//   a successful read makes five reads of the single-port ring memory, one
//   byte per cycle; the bytes come from the registered read data and the
//   result is then queued. in_i.ready stays low during the fetch. a failed
//   read is queued at the accepting edge like any other item.
//   the config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the four command
//   codes and the timeout limit; write it only while the block is idle.
//   reset clears indexes, phase, flags and counters; the codes go to zero
//   and the limit to 50. ring contents are not cleared.
//   if the receiver stalls, results pile up in the queue; once it holds two
//   results in_i.ready drops until out_o takes one.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_five_byte_packet_framer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rfpf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [7:0]                        cfg_data_i,
  rfpf_in_if.sink                                in_i,
  rfpf_out_if.source                             out_o
);

  // packet phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_B1   = 3'd1;
  localparam logic [2:0] PH_B2   = 3'd2;
  localparam logic [2:0] PH_B3   = 3'd3;
  localparam logic [2:0] PH_B4   = 3'd4;

  localparam logic [2:0] LAST_SLOT = 3'(rfpf_pkg::PKT_LEN - 1);
  localparam logic [2:0] NUM_SLOTS = 3'(rfpf_pkg::PKT_LEN);

  // configuration
  logic [3:0][7:0] cmd_code_q;
  logic [7:0]      limit_q;

  // framer state
  rfpf_pkg::idx_t wr_idx_q, wr_idx_d;
  rfpf_pkg::idx_t rd_idx_q, rd_idx_d;
  logic [2:0]     phase_q, phase_d;
  logic [7:0]     tick_q, tick_d;
  logic           ready_q, ready_d;
  logic           tmo_q, tmo_d;

  // packet fetch sequencer
  logic           busy_q;
  logic [2:0]     iss_cnt_q;
  rfpf_pkg::idx_t fetch_addr_q;
  logic           cap_vld_q;
  logic [2:0]     cap_slot_q;
  logic [7:0]     pkt_q [4];

  logic                 accept;
  logic                 start_fetch;
  logic                 issuing;
  logic                 fetch_done;
  logic                 mem_we;
  rfpf_pkg::idx_t       mem_addr;
  logic [7:0]           mem_rdata;
  logic                 push;
  rfpf_pkg::res_t       push_data;
  rfpf_pkg::res_t       head;
  rfpf_pkg::fifo_stat_t fifo_stat;
  rfpf_pkg::idx_ext_t   avail;
  logic [8:0]           tick_sum;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !busy_q && !fifo_stat.full;
  assign avail       = rfpf_pkg::idx_avail(wr_idx_q, rd_idx_q);
  assign tick_sum    = {1'b0, tick_q} + 9'd1;

  // item decode and state update
  always_comb begin
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    ready_d     = ready_q;
    tmo_d       = tmo_q;
    mem_we      = 1'b0;
    start_fetch = 1'b0;
    if (accept) begin
      unique case (in_i.action)
        rfpf_pkg::ACT_BYTE: begin
          // byte always lands at the write index, kept only if it advances
          mem_we = 1'b1;
          tick_d = 8'd0;
          case (phase_q) inside
            PH_B1, PH_B2, PH_B3: begin
              wr_idx_d = rfpf_pkg::idx_next(wr_idx_q);
              phase_d  = phase_q + 3'd1;
            end
            PH_B4: begin
              wr_idx_d = rfpf_pkg::idx_next(wr_idx_q);
              phase_d  = PH_IDLE;
              ready_d  = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE;
              if (rfpf_pkg::code_match(cmd_code_q, in_i.rx_byte)) begin
                wr_idx_d = rfpf_pkg::idx_next(wr_idx_q);
                phase_d  = PH_B1;
              end
            end
          endcase
        end
        rfpf_pkg::ACT_ERR: begin
          wr_idx_d = rfpf_pkg::idx_back(wr_idx_q, phase_q);
          phase_d  = PH_IDLE;
          tick_d   = 8'd0;
        end
        rfpf_pkg::ACT_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (tick_sum > {1'b0, limit_q}) begin
              wr_idx_d = rfpf_pkg::idx_back(wr_idx_q, phase_q);
              phase_d  = PH_IDLE;
              tick_d   = 8'd0;
              tmo_d    = 1'b1;
            end else begin
              tick_d = tick_sum[7:0];
            end
          end else begin
            tmo_d = 1'b0;
          end
        end
        rfpf_pkg::ACT_READ: begin
          // outcome is known from the indexes, only the bytes need the ring
          if (ready_q) begin
            if (avail >= rfpf_pkg::PKT_LEN_EXT) begin
              start_fetch = 1'b1;
              rd_idx_d    = rfpf_pkg::idx_add_pkt(rd_idx_q);
              if (avail == rfpf_pkg::PKT_LEN_EXT) begin
                ready_d = 1'b0;
              end
            end else begin
              ready_d = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_code_q <= '0;
      limit_q    <= rfpf_pkg::TIMEOUT_RESET;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      phase_q    <= PH_IDLE;
      tick_q     <= 8'd0;
      ready_q    <= 1'b0;
      tmo_q      <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      ready_q  <= ready_d;
      tmo_q    <= tmo_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rfpf_pkg::CFG_CODE_A: cmd_code_q[0] <= cfg_data_i;
          rfpf_pkg::CFG_CODE_B: cmd_code_q[1] <= cfg_data_i;
          rfpf_pkg::CFG_CODE_C: cmd_code_q[2] <= cfg_data_i;
          rfpf_pkg::CFG_CODE_D: cmd_code_q[3] <= cfg_data_i;
          rfpf_pkg::CFG_LIMIT:  limit_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // fetch: issue five reads, take each byte from the read data in the next cycle
  assign issuing    = busy_q && (iss_cnt_q < NUM_SLOTS);
  assign fetch_done = cap_vld_q && (cap_slot_q == LAST_SLOT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_cnt_q  <= 3'd0;
      cap_vld_q  <= 1'b0;
      cap_slot_q <= 3'd0;
    end else begin
      cap_vld_q  <= issuing;
      cap_slot_q <= iss_cnt_q;
      if (start_fetch) begin
        busy_q    <= 1'b1;
        iss_cnt_q <= 3'd0;
      end else if (issuing) begin
        iss_cnt_q <= iss_cnt_q + 3'd1;
      end
      if (fetch_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_fetch) begin
      fetch_addr_q <= rd_idx_q;
    end else if (issuing) begin
      fetch_addr_q <= rfpf_pkg::idx_next(fetch_addr_q);
    end
    if (cap_vld_q) begin
      case (cap_slot_q)
        3'd0:    pkt_q[0] <= mem_rdata;
        3'd1:    pkt_q[1] <= mem_rdata;
        3'd2:    pkt_q[2] <= mem_rdata;
        3'd3:    pkt_q[3] <= mem_rdata;
        default: ;
      endcase
    end
  end

  // byte writes only happen while no fetch runs, so one port serves both
  assign mem_addr = busy_q ? fetch_addr_q : wr_idx_q;

  rfpf_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (issuing),
    .addr_i  (mem_addr),
    .wdata_i (in_i.rx_byte),
    .rdata_o (mem_rdata)
  );

  // result assembly
  assign push = fetch_done || (accept && !start_fetch);

  always_comb begin
    if (fetch_done) begin
      push_data.packet_ready = ready_q;
      push_data.read_ok      = 1'b1;
      push_data.pkt_byte0    = pkt_q[0];
      push_data.pkt_byte1    = pkt_q[1];
      push_data.pkt_byte2    = pkt_q[2];
      push_data.pkt_byte3    = pkt_q[3];
      push_data.pkt_byte4    = mem_rdata;
      push_data.timeout_flag = tmo_q;
    end else begin
      push_data.packet_ready = ready_d;
      push_data.read_ok      = 1'b0;
      push_data.pkt_byte0    = 8'd0;
      push_data.pkt_byte1    = 8'd0;
      push_data.pkt_byte2    = 8'd0;
      push_data.pkt_byte3    = 8'd0;
      push_data.pkt_byte4    = 8'd0;
      push_data.timeout_flag = tmo_d;
    end
  end

  rfpf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (out_o.valid && out_o.ready),
    .data_o      (head),
    .stat_o      (fifo_stat)
  );

  assign out_o.valid        = !fifo_stat.empty;
  assign out_o.packet_ready = head.packet_ready;
  assign out_o.read_ok      = head.read_ok;
  assign out_o.pkt_byte0    = head.pkt_byte0;
  assign out_o.pkt_byte1    = head.pkt_byte1;
  assign out_o.pkt_byte2    = head.pkt_byte2;
  assign out_o.pkt_byte3    = head.pkt_byte3;
  assign out_o.pkt_byte4    = head.pkt_byte4;
  assign out_o.timeout_flag = head.timeout_flag;

  // checks
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_B4)
    else $error("packet phase out of range");

  a_fetch_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fetch |=> busy_q && (iss_cnt_q == 3'd0))
    else $error("fetch did not start after read");

  a_fetch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_done |=> !busy_q && !cap_vld_q)
    else $error("fetch did not finish after last byte");

  a_no_write_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !mem_we)
    else $error("ring write during packet fetch");

endmodule

`default_nettype wire

// ===== design/rfpf_ram.sv =====
// ----------------------------------------------------------------------------
// rfpf_ram
// single-port byte ring storage, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rfpf_ram (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic                re_i,
  input  wire rfpf_pkg::idx_t      addr_i,
  input  wire logic [7:0]          wdata_i,
  output      logic [7:0]          rdata_o
);

  logic [7:0] mem_q [rfpf_pkg::BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/rfpf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rfpf_out_fifo
// two-entry result queue between framer logic and the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module rfpf_out_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire rfpf_pkg::res_t       push_data_i,
  input  wire logic                 pop_i,
  output      rfpf_pkg::res_t       data_o,
  output      rfpf_pkg::fifo_stat_t stat_o
);

  rfpf_pkg::res_t ent_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o       = ent_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = cnt_q[1];

endmodule

`default_nettype wire

// ===== tb/rx_five_byte_packet_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_five_byte_packet_framer_tb
// drives byte, line error, tick and read items into the packet framer with
// random gaps on both channels, predicts every result item from a model of
// the ring, the packet phase and the timeout counter kept in a scoreboard
// class, and compares each result field by field in order
// ----------------------------------------------------------------------------
module rx_five_byte_packet_framer_tb;

  localparam int unsigned GAP_MAX         = 13;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned CFG_GAP_CYCLES  = 8;
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  // packet phase values of the framer
  localparam logic [2:0] PHASE_IDLE = 3'd0;
  localparam logic [2:0] PHASE_ID   = 3'd1;
  localparam logic [2:0] PHASE_PRE  = 3'd3;
  localparam logic [2:0] PHASE_TAIL = 3'd4;

  // scoreboard: mirrors the ring and the framing state, queues one
  // predicted result per accepted item and checks results in order
  class framer_checker;
    logic [7:0] codes [4];
    logic [7:0] limit;
    logic [7:0] ring [rfpf_pkg::BUFFER_DEPTH];
    rfpf_pkg::idx_t wr_ptr;
    rfpf_pkg::idx_t rd_ptr;
    logic [2:0] phase;
    logic [7:0] ticks;
    logic       pkt_waiting;
    logic       tmo_latched;
    rfpf_pkg::res_t due_results [$];
    int unsigned mismatches;
    int unsigned strays;
    int unsigned reports;
    int unsigned results_seen;
    int unsigned packets_framed;
    int unsigned reads_ok;
    int unsigned reads_refused;
    int unsigned timeouts;

    function new();
      foreach (codes[k]) codes[k] = 8'd0;
      foreach (ring[k]) ring[k] = 8'd0;
      limit          = rfpf_pkg::TIMEOUT_RESET;
      wr_ptr         = '0;
      rd_ptr         = '0;
      phase          = PHASE_IDLE;
      ticks          = 8'd0;
      pkt_waiting    = 1'b0;
      tmo_latched    = 1'b0;
      mismatches     = 0;
      strays         = 0;
      reports        = 0;
      results_seen   = 0;
      packets_framed = 0;
      reads_ok       = 0;
      reads_refused  = 0;
      timeouts       = 0;
    endfunction

    function void set_reg(logic [rfpf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        rfpf_pkg::CFG_CODE_A: codes[0] = val;
        rfpf_pkg::CFG_CODE_B: codes[1] = val;
        rfpf_pkg::CFG_CODE_C: codes[2] = val;
        rfpf_pkg::CFG_CODE_D: codes[3] = val;
        rfpf_pkg::CFG_LIMIT:  limit    = val;
        default: ;
      endcase
    endfunction

    function rfpf_pkg::idx_t ring_step(rfpf_pkg::idx_t i);
      return rfpf_pkg::idx_t'((int'(i) + 1) % rfpf_pkg::BUFFER_DEPTH);
    endfunction

    function bit is_command(logic [7:0] b);
      bit hit;
      bit done;
      hit  = 1'b0;
      done = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (!done) begin
          if (codes[k] == 8'd0) begin
            done = 1'b1;
          end else if (codes[k] == b) begin
            hit  = 1'b1;
            done = 1'b1;
          end
        end
      end
      return hit;
    endfunction

    // roll the write pointer back over the partial packet
    function void discard_partial();
      wr_ptr = rfpf_pkg::idx_t'((int'(wr_ptr) + rfpf_pkg::BUFFER_DEPTH - int'(phase))
                                % rfpf_pkg::BUFFER_DEPTH);
      phase  = PHASE_IDLE;
      ticks  = 8'd0;
    endfunction

    function void frame_item(logic [1:0] act, logic [7:0] b);
      rfpf_pkg::res_t r;
      logic [8:0]     t;
      rfpf_pkg::idx_t p;
      logic [7:0]     got_bytes [rfpf_pkg::PKT_LEN];
      bit             ok;
      r  = '0;
      ok = 1'b0;
      case (act)
        rfpf_pkg::ACT_BYTE: begin
          ring[wr_ptr] = b;
          if (phase >= PHASE_ID && phase <= PHASE_PRE) begin
            wr_ptr = ring_step(wr_ptr);
            phase  = phase + 3'd1;
          end else if (phase == PHASE_TAIL) begin
            wr_ptr      = ring_step(wr_ptr);
            phase       = PHASE_IDLE;
            pkt_waiting = 1'b1;
            packets_framed++;
          end else begin
            phase = PHASE_IDLE;
            if (is_command(b)) begin
              wr_ptr = ring_step(wr_ptr);
              phase  = PHASE_ID;
            end
          end
          ticks = 8'd0;
        end
        rfpf_pkg::ACT_ERR: discard_partial();
        rfpf_pkg::ACT_TICK: begin
          if (phase != PHASE_IDLE) begin
            t = {1'b0, ticks} + 9'd1;
            if (t > {1'b0, limit}) begin
              discard_partial();
              tmo_latched = 1'b1;
              timeouts++;
            end else begin
              ticks = t[7:0];
            end
          end else begin
            tmo_latched = 1'b0;
          end
        end
        default: begin
          if (pkt_waiting) begin
            p  = rd_ptr;
            ok = 1'b1;
            for (int j = 0; j < rfpf_pkg::PKT_LEN && ok; j++) begin
              if (p == wr_ptr) begin
                pkt_waiting = 1'b0;
                ok          = 1'b0;
              end else begin
                got_bytes[j] = ring[p];
                p            = ring_step(p);
              end
            end
            if (ok) begin
              rd_ptr = p;
              if (p == wr_ptr) pkt_waiting = 1'b0;
              r.pkt_byte0 = got_bytes[0];
              r.pkt_byte1 = got_bytes[1];
              r.pkt_byte2 = got_bytes[2];
              r.pkt_byte3 = got_bytes[3];
              r.pkt_byte4 = got_bytes[4];
            end
          end
          if (ok) reads_ok++;
          else reads_refused++;
        end
      endcase
      r.packet_ready = pkt_waiting;
      r.read_ok      = ok;
      r.timeout_flag = tmo_latched;
      due_results.push_back(r);
    endfunction

    function void flag(string msg);
      if (reports < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
      reports++;
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got_v);
      if (got_v !== want) begin
        mismatches++;
        flag($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
                       results_seen, name, want, got_v));
      end
    endfunction

    function void check_result(rfpf_pkg::res_t got);
      rfpf_pkg::res_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        strays++;
        flag($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = due_results.pop_front();
      field_check("packet_ready", 8'(want.packet_ready), 8'(got.packet_ready));
      field_check("read_ok",      8'(want.read_ok),      8'(got.read_ok));
      field_check("pkt_byte0",    want.pkt_byte0,        got.pkt_byte0);
      field_check("pkt_byte1",    want.pkt_byte1,        got.pkt_byte1);
      field_check("pkt_byte2",    want.pkt_byte2,        got.pkt_byte2);
      field_check("pkt_byte3",    want.pkt_byte3,        got.pkt_byte3);
      field_check("pkt_byte4",    want.pkt_byte4,        got.pkt_byte4);
      field_check("timeout_flag", 8'(want.timeout_flag), 8'(got.timeout_flag));
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function int unsigned errors();
      return mismatches + strays + due_results.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [rfpf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]                     cfg_data;

  rfpf_in_if  in_ch ();
  rfpf_out_if out_ch ();

  rx_five_byte_packet_framer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  framer_checker sb;

  // sender side bookkeeping
  bit          valid_up;
  bit          src_quiet;
  bit          dst_quiet;
  int unsigned next_gap;
  int unsigned items_sent;
  int unsigned cfg_loads;

  // current register settings: codes a to d, then the timeout limit
  logic [7:0] cfg_plan [5];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("rx_five_byte_packet_framer_tb: done, errors");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // pick an id from the live part of the code list, now and then a stray
  function automatic logic [7:0] pick_command();
    int unsigned live;
    live = 0;
    while (live < 4 && cfg_plan[live] != 8'd0) live++;
    if (live == 0 || $urandom_range(0, 19) == 0) return rand_byte();
    return cfg_plan[$urandom_range(0, live - 1)];
  endfunction

  // one input item: wait out the gap, raise valid, hold until accepted;
  // valid stays high when the next item follows with no gap
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    repeat (next_gap) @(posedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= b;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.frame_item(act, b);
    items_sent++;
    // switch between gapped and back-to-back stretches now and then
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    next_gap = src_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (next_gap > 0) begin
      in_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic hold_sender();
    if (valid_up) begin
      in_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic tick_burst(input int unsigned n);
    repeat (n) send_item(rfpf_pkg::ACT_TICK, rand_byte());
  endtask

  task automatic put_reg(input logic [rfpf_pkg::CFG_IDX_W-1:0] idx,
                         input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // registers change only with the block idle and the result queue empty
  task automatic reconfigure(input logic [7:0] ca, input logic [7:0] cb,
                             input logic [7:0] cc, input logic [7:0] cd,
                             input logic [7:0] lim);
    hold_sender();
    repeat (CFG_GAP_CYCLES) @(posedge clk_i);
    cfg_plan[0] = ca;
    cfg_plan[1] = cb;
    cfg_plan[2] = cc;
    cfg_plan[3] = cd;
    cfg_plan[4] = lim;
    put_reg(rfpf_pkg::CFG_CODE_A, ca);
    put_reg(rfpf_pkg::CFG_CODE_B, cb);
    put_reg(rfpf_pkg::CFG_CODE_C, cc);
    put_reg(rfpf_pkg::CFG_CODE_D, cd);
    put_reg(rfpf_pkg::CFG_LIMIT, lim);
    cfg_we <= 1'b0;
    cfg_loads++;
  endtask

  // one random sequence: mostly whole packets with ticks between bytes,
  // plus reads, broken packets that end in an error or a timeout, and noise
  task automatic run_random_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    logic [7:0]  lim;
    lim  = cfg_plan[4];
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      send_item(rfpf_pkg::ACT_BYTE, pick_command());
      for (k = 0; k < 4; k++) begin
        if (lim != 8'd0 && $urandom_range(0, 3) == 0) begin
          tick_burst($urandom_range(1, (lim < 8'd3) ? int'(lim) : 3));
        end else if (lim <= 8'd10 && $urandom_range(0, 9) == 0) begin
          // right at the limit, must not time out
          tick_burst(int'(lim));
        end
        send_item(rfpf_pkg::ACT_BYTE, rand_byte());
      end
      if ($urandom_range(0, 1) == 0) send_item(rfpf_pkg::ACT_READ, rand_byte());
    end else if (kind < 75) begin
      send_item(rfpf_pkg::ACT_READ, rand_byte());
    end else if (kind < 87) begin
      send_item(rfpf_pkg::ACT_BYTE, pick_command());
      n = $urandom_range(0, 3);
      repeat (n) send_item(rfpf_pkg::ACT_BYTE, rand_byte());
      if ((lim <= 8'd20 || $urandom_range(0, 7) == 0) && $urandom_range(0, 1) == 0) begin
        tick_burst(int'(lim) + 1);
      end else begin
        send_item(rfpf_pkg::ACT_ERR, rand_byte());
      end
      // an idle tick clears the timeout flag
      if ($urandom_range(0, 1) == 0) send_item(rfpf_pkg::ACT_TICK, rand_byte());
    end else if (kind < 95) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(2'($urandom_range(0, 3)), rand_byte());
    end else begin
      send_item(($urandom_range(0, 1) == 0) ? rfpf_pkg::ACT_ERR : rfpf_pkg::ACT_TICK,
                rand_byte());
    end
  endtask

  // result side: random stalls per item, with stretches of none
  initial begin : result_sink
    int unsigned    gap;
    rfpf_pkg::res_t got;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = dst_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got.packet_ready = out_ch.packet_ready;
      got.read_ok      = out_ch.read_ok;
      got.pkt_byte0    = out_ch.pkt_byte0;
      got.pkt_byte1    = out_ch.pkt_byte1;
      got.pkt_byte2    = out_ch.pkt_byte2;
      got.pkt_byte3    = out_ch.pkt_byte3;
      got.pkt_byte4    = out_ch.pkt_byte4;
      got.timeout_flag = out_ch.timeout_flag;
      sb.check_result(got);
      if ($urandom_range(0, 29) == 0) dst_quiet = !dst_quiet;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned phase_end;
    logic [7:0]  lim;
    logic [7:0]  cb;
    logic [7:0]  cc;
    logic [7:0]  cd;

    sb = new();
    // every input known from time zero, reset held low
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= rfpf_pkg::CFG_CODE_A;
    cfg_data      <= 8'd0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= rfpf_pkg::ACT_BYTE;
    in_ch.rx_byte <= 8'd0;
    valid_up   = 1'b0;
    src_quiet  = 1'b0;
    next_gap   = 0;
    items_sent = 0;
    cfg_loads  = 0;
    cfg_plan[0] = 8'd0;
    cfg_plan[1] = 8'd0;
    cfg_plan[2] = 8'd0;
    cfg_plan[3] = 8'd0;
    cfg_plan[4] = rfpf_pkg::TIMEOUT_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every code is zero, so no byte starts a packet
    send_item(rfpf_pkg::ACT_BYTE, 8'h00);
    send_item(rfpf_pkg::ACT_BYTE, 8'hFF);
    send_item(rfpf_pkg::ACT_TICK, 8'h00);
    send_item(rfpf_pkg::ACT_READ, 8'hFF);
    send_item(rfpf_pkg::ACT_ERR, 8'h00);

    // zero in slot c ends the list, so the code in slot d is dead
    reconfigure(8'h01, 8'hFF, 8'h00, 8'h55, 8'd0);
    send_item(rfpf_pkg::ACT_BYTE, 8'h55);
    // full packet with extreme data, read back, then a read on empty
    send_item(rfpf_pkg::ACT_BYTE, 8'hFF);
    send_item(rfpf_pkg::ACT_BYTE, 8'h00);
    send_item(rfpf_pkg::ACT_BYTE, 8'hFF);
    send_item(rfpf_pkg::ACT_BYTE, 8'hAA);
    send_item(rfpf_pkg::ACT_BYTE, 8'h55);
    send_item(rfpf_pkg::ACT_READ, 8'h00);
    send_item(rfpf_pkg::ACT_READ, 8'h00);
    // limit zero: the first tick on a partial packet times it out
    send_item(rfpf_pkg::ACT_BYTE, 8'h01);
    send_item(rfpf_pkg::ACT_BYTE, 8'h12);
    send_item(rfpf_pkg::ACT_TICK, 8'h00);
    // tick while idle clears the latched timeout
    send_item(rfpf_pkg::ACT_TICK, 8'hFF);
    // a packet, a partial behind it, a read that leaves ready set,
    // an error that drops the partial, then a read that runs short
    send_item(rfpf_pkg::ACT_BYTE, 8'h01);
    send_item(rfpf_pkg::ACT_BYTE, 8'h01);
    send_item(rfpf_pkg::ACT_BYTE, 8'h02);
    send_item(rfpf_pkg::ACT_BYTE, 8'h03);
    send_item(rfpf_pkg::ACT_BYTE, 8'h04);
    send_item(rfpf_pkg::ACT_BYTE, 8'h01);
    send_item(rfpf_pkg::ACT_BYTE, 8'h77);
    send_item(rfpf_pkg::ACT_READ, 8'h00);
    send_item(rfpf_pkg::ACT_ERR, 8'hFF);
    send_item(rfpf_pkg::ACT_READ, 8'h00);

    // random phases, each under its own register settings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: lim = 8'd254;
        1: lim = 8'd0;
        2: lim = 8'd1;
        3: lim = 8'd2;
        default: lim = 8'($urandom_range(3, 12));
      endcase
      cb = ($urandom_range(0, 4) == 0) ? 8'd0 : rand_byte();
      cc = ($urandom_range(0, 4) == 0) ? 8'd0 : rand_byte();
      cd = ($urandom_range(0, 4) == 0) ? 8'd0 : rand_byte();
      if (ph == 0) begin
        // all four slots live, slot d at the top code
        cb = 8'($urandom_range(1, 255));
        cc = 8'($urandom_range(1, 255));
        cd = 8'hFF;
      end
      if (ph == 1) cb = 8'd0;
      reconfigure(8'($urandom_range(1, 255)), cb, cc, cd, lim);
      phase_end = items_sent + ITEMS_PER_PHASE;
      if (lim > 8'd20) begin
        // long limit: survive exactly the limit, then go one past it
        send_item(rfpf_pkg::ACT_BYTE, pick_command());
        tick_burst(int'(lim));
        send_item(rfpf_pkg::ACT_BYTE, rand_byte());
        tick_burst(int'(lim) + 1);
      end
      while (items_sent < phase_end) begin
        // now and then let the pipeline drain completely
        if ($urandom_range(0, 59) == 0) hold_sender();
        run_random_sequence();
      end
    end

    hold_sender();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("coverage: %0d items over %0d register settings, %0d packets framed",
             items_sent, cfg_loads, sb.packets_framed);
    $display("coverage: %0d reads returned a packet, %0d refused, %0d timeouts",
             sb.reads_ok, sb.reads_refused, sb.timeouts);
    if (sb.errors() == 0) begin
      $display("rx_five_byte_packet_framer_tb: done, clean");
    end else begin
      $display("%0d field mismatches, %0d stray results, %0d results missing",
               sb.mismatches, sb.strays, sb.pending());
      $display("rx_five_byte_packet_framer_tb: done, errors");
    end
    $finish;
  end

endmodule
